// ----- rtl/clpc_pkg.sv -----
// Package for the charger LED pattern controller: codes, LED masks and the result beat type.
`default_nettype none
package clpc_pkg;

  localparam int ACTION_W = 4;
  localparam int MODE_W   = 3;
  localparam int MV_W     = 15;
  localparam int PACK_W   = 16;
  localparam int LEVEL_W  = 3;
  localparam int LED_W    = 6;
  localparam int CFG_IDX_W = 3;

  localparam logic [ACTION_W-1:0] ACT_TICK       = 4'd0;
  localparam logic [ACTION_W-1:0] ACT_SET_CHARGE = 4'd1;
  localparam logic [ACTION_W-1:0] ACT_SET_JUMP   = 4'd2;
  localparam logic [ACTION_W-1:0] ACT_SET_ERROR  = 4'd3;
  localparam logic [ACTION_W-1:0] ACT_ALL_ON     = 4'd4;
  localparam logic [ACTION_W-1:0] ACT_ALL_OFF    = 4'd5;
  localparam logic [ACTION_W-1:0] ACT_CHARGE_OFF = 4'd6;
  localparam logic [ACTION_W-1:0] ACT_JUMP_OFF   = 4'd7;
  localparam logic [ACTION_W-1:0] ACT_CHEMISTRY  = 4'd8;
  localparam logic [ACTION_W-1:0] ACT_PACK_LEVEL = 4'd9;

  localparam logic [MODE_W-1:0] CHG_OFF       = 3'd0;
  localparam logic [MODE_W-1:0] CHG_WAIT      = 3'd1;
  localparam logic [MODE_W-1:0] CHG_CHARGING  = 3'd2;
  localparam logic [MODE_W-1:0] CHG_CV        = 3'd3;
  localparam logic [MODE_W-1:0] CHG_MAINT     = 3'd4;
  localparam logic [MODE_W-1:0] CHG_SULFATED  = 3'd5;
  localparam logic [MODE_W-1:0] CHG_RECOV_TO  = 3'd6;
  localparam logic [MODE_W-1:0] CHG_CC_TO     = 3'd7;

  localparam logic [MODE_W-1:0] JMP_OFF       = 3'd0;
  localparam logic [MODE_W-1:0] JMP_WAIT      = 3'd1;
  localparam logic [MODE_W-1:0] JMP_ACTIVE    = 3'd2;
  localparam logic [MODE_W-1:0] JMP_DONE      = 3'd3;
  localparam logic [MODE_W-1:0] JMP_PACK_ERR  = 3'd4;

  localparam logic [MODE_W-1:0] ERR_NONE       = 3'd0;
  localparam logic [MODE_W-1:0] ERR_UNCAL      = 3'd1;
  localparam logic [MODE_W-1:0] ERR_CAL_OK     = 3'd2;
  localparam logic [MODE_W-1:0] ERR_TEST       = 3'd3;
  localparam logic [MODE_W-1:0] ERR_POLARITY   = 3'd4;
  localparam logic [MODE_W-1:0] ERR_CONTENTION = 3'd5;
  localparam logic [MODE_W-1:0] ERR_LOW_PACK   = 3'd6;

  localparam logic [LED_W-1:0] LED_CA  = 6'h01;
  localparam logic [LED_W-1:0] LED_CG  = 6'h02;
  localparam logic [LED_W-1:0] LED_JA  = 6'h04;
  localparam logic [LED_W-1:0] LED_JG  = 6'h08;
  localparam logic [LED_W-1:0] LED_LI  = 6'h10;
  localparam logic [LED_W-1:0] LED_AG  = 6'h20;
  localparam logic [LED_W-1:0] LED_ALL = 6'h3F;

  localparam logic [CFG_IDX_W-1:0] CFG_MAINTAIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_JUMP_READY = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCESSORY  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW        = 3'd4;

  localparam logic [MV_W-1:0] RST_MAINTAIN   = 15'd15000;
  localparam logic [MV_W-1:0] RST_HIGH       = 15'd14500;
  localparam logic [MV_W-1:0] RST_JUMP_READY = 15'd14000;
  localparam logic [MV_W-1:0] RST_ACCESSORY  = 15'd13000;
  localparam logic [MV_W-1:0] RST_LOW        = 15'd12000;

  typedef struct packed {
    logic [LED_W-1:0]   leds;
    logic [LEVEL_W-1:0] level;
  } result_t;

endpackage
`default_nettype wire

// ----- rtl/charger_led_pattern_controller.sv -----
// Top level of the charger and jump-pack LED pattern controller.
`default_nettype none
// Takes one event per cycle while in_stall is low and returns one beat of LED
// states per event. Each event is decoded and applied to the mode, blink and
// LED state combinationally; the result beat is registered, with a one-beat
// skid register behind it so that an event is still taken while the output is
// stalled. in_stall rises only when both result registers hold beats. Threshold
// writes are taken at any time (cfg_ready is tied high).
module charger_led_pattern_controller #(
  parameter int PATTERN_SLOTS = 10
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [clpc_pkg::ACTION_W-1:0]   action,
  input  wire logic [clpc_pkg::MODE_W-1:0]     mode_code,
  input  wire logic                            lithium_on,
  input  wire logic                            agm_on,
  input  wire logic signed [clpc_pkg::PACK_W-1:0] pack_millivolts,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 charge_amber,
  output logic                                 charge_green,
  output logic                                 jump_amber,
  output logic                                 jump_green,
  output logic                                 lithium_led,
  output logic                                 agm_led,
  output logic [clpc_pkg::LEVEL_W-1:0]         pack_level,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [clpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [clpc_pkg::MV_W-1:0]       cfg_data
);

  localparam int SLOT_W = $clog2(PATTERN_SLOTS);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(PATTERN_SLOTS - 1);

  logic [clpc_pkg::MV_W-1:0] maintain_level_mv;
  logic [clpc_pkg::MV_W-1:0] high_level_mv;
  logic [clpc_pkg::MV_W-1:0] jump_ready_level_mv;
  logic [clpc_pkg::MV_W-1:0] accessory_level_mv;
  logic [clpc_pkg::MV_W-1:0] low_level_mv;

  logic [clpc_pkg::MODE_W-1:0]  error_mode, error_mode_next;
  logic [clpc_pkg::MODE_W-1:0]  charge_mode, charge_mode_next;
  logic [clpc_pkg::MODE_W-1:0]  jump_mode, jump_mode_next;
  logic [SLOT_W-1:0]            blink_slot, blink_slot_next;
  logic [clpc_pkg::LED_W-1:0]   led_states, led_states_next;
  logic [clpc_pkg::LEVEL_W-1:0] shown_level, shown_level_next;

  logic [SLOT_W:0]              slot_ext;
  logic [SLOT_W-1:0]            slot_adv;
  logic                         lit1, lit2, lit3;
  logic [clpc_pkg::LEVEL_W-1:0] graded;

  clpc_pkg::result_t res_new, res_out, res_skid;
  logic skid_valid;
  logic accept_in, take_out;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid;
  assign accept_in = in_valid & ~skid_valid;
  assign take_out  = out_valid & ~out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      maintain_level_mv   <= clpc_pkg::RST_MAINTAIN;
      high_level_mv       <= clpc_pkg::RST_HIGH;
      jump_ready_level_mv <= clpc_pkg::RST_JUMP_READY;
      accessory_level_mv  <= clpc_pkg::RST_ACCESSORY;
      low_level_mv        <= clpc_pkg::RST_LOW;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        clpc_pkg::CFG_MAINTAIN:   maintain_level_mv   <= cfg_data;
        clpc_pkg::CFG_HIGH:       high_level_mv       <= cfg_data;
        clpc_pkg::CFG_JUMP_READY: jump_ready_level_mv <= cfg_data;
        clpc_pkg::CFG_ACCESSORY:  accessory_level_mv  <= cfg_data;
        clpc_pkg::CFG_LOW:        low_level_mv        <= cfg_data;
        default: ;
      endcase
    end
  end

  // blink pattern: slot lit when even and below twice the pulse count
  assign slot_ext = {1'b0, blink_slot};
  assign lit1 = ~blink_slot[0] && (slot_ext < (SLOT_W+1)'(2));
  assign lit2 = ~blink_slot[0] && (slot_ext < (SLOT_W+1)'(4));
  assign lit3 = ~blink_slot[0] && (slot_ext < (SLOT_W+1)'(6));
  assign slot_adv = (blink_slot == SLOT_LAST) ? '0 : blink_slot + SLOT_W'(1);

  always_comb begin
    if (pack_millivolts > $signed({1'b0, maintain_level_mv}))
      graded = 3'd5;
    else if (pack_millivolts > $signed({1'b0, high_level_mv}))
      graded = 3'd4;
    else if (pack_millivolts > $signed({1'b0, jump_ready_level_mv}))
      graded = 3'd3;
    else if (pack_millivolts > $signed({1'b0, accessory_level_mv}))
      graded = 3'd2;
    else if (pack_millivolts > $signed({1'b0, low_level_mv}))
      graded = 3'd1;
    else
      graded = 3'd0;
  end

  always_comb begin
    error_mode_next  = error_mode;
    charge_mode_next = charge_mode;
    jump_mode_next   = jump_mode;
    blink_slot_next  = blink_slot;
    led_states_next  = led_states;
    shown_level_next = shown_level;
    unique case (action)
      clpc_pkg::ACT_TICK: begin
        if (error_mode == clpc_pkg::ERR_NONE) begin
          case (charge_mode) inside
            clpc_pkg::CHG_WAIT: led_states_next = led_states_next ^ clpc_pkg::LED_CA;
            clpc_pkg::CHG_CV:   led_states_next = led_states_next ^ clpc_pkg::LED_CG;
            clpc_pkg::CHG_SULFATED, clpc_pkg::CHG_RECOV_TO, clpc_pkg::CHG_CC_TO: begin
              if ((charge_mode == clpc_pkg::CHG_SULFATED && lit1) ||
                  (charge_mode == clpc_pkg::CHG_RECOV_TO && lit2) ||
                  (charge_mode == clpc_pkg::CHG_CC_TO && lit3))
                led_states_next = led_states_next | (clpc_pkg::LED_CA | clpc_pkg::LED_CG);
              else
                led_states_next = led_states_next & ~(clpc_pkg::LED_CA | clpc_pkg::LED_CG);
              blink_slot_next = slot_adv;
            end
            default: ;
          endcase
          case (jump_mode)
            clpc_pkg::JMP_WAIT:     led_states_next = led_states_next ^ clpc_pkg::LED_JG;
            clpc_pkg::JMP_PACK_ERR: led_states_next = led_states_next ^ clpc_pkg::LED_JA;
            default: ;
          endcase
        end else begin
          case (error_mode)
            clpc_pkg::ERR_UNCAL: begin
              if (lit1)
                led_states_next = led_states | (clpc_pkg::LED_CA | clpc_pkg::LED_CG);
              else
                led_states_next = led_states & ~(clpc_pkg::LED_CA | clpc_pkg::LED_CG);
              blink_slot_next = slot_adv;
            end
            clpc_pkg::ERR_CAL_OK:
              led_states_next = led_states ^ (clpc_pkg::LED_CG | clpc_pkg::LED_JG);
            clpc_pkg::ERR_TEST:
              led_states_next = led_states ^ clpc_pkg::LED_ALL;
            clpc_pkg::ERR_POLARITY:
              led_states_next = led_states ^ (clpc_pkg::LED_CA | clpc_pkg::LED_CG);
            clpc_pkg::ERR_CONTENTION:
              led_states_next = led_states ^ (clpc_pkg::LED_CA | clpc_pkg::LED_JA);
            clpc_pkg::ERR_LOW_PACK: begin
              if (lit1)
                led_states_next = led_states | clpc_pkg::LED_JA;
              else
                led_states_next = led_states & ~clpc_pkg::LED_JA;
              blink_slot_next = slot_adv;
            end
            default: ;
          endcase
        end
      end
      clpc_pkg::ACT_SET_CHARGE: begin
        if (mode_code != charge_mode) begin
          charge_mode_next = mode_code;
          case (mode_code) inside
            clpc_pkg::CHG_WAIT:
              led_states_next = led_states & ~(clpc_pkg::LED_CA | clpc_pkg::LED_CG);
            clpc_pkg::CHG_CHARGING, clpc_pkg::CHG_CV:
              led_states_next = (led_states | clpc_pkg::LED_CA) & ~clpc_pkg::LED_CG;
            clpc_pkg::CHG_MAINT:
              led_states_next = (led_states | clpc_pkg::LED_CG) & ~clpc_pkg::LED_CA;
            clpc_pkg::CHG_SULFATED, clpc_pkg::CHG_RECOV_TO, clpc_pkg::CHG_CC_TO: begin
              blink_slot_next = '0;
              led_states_next = led_states & ~(clpc_pkg::LED_CA | clpc_pkg::LED_CG |
                                               clpc_pkg::LED_LI | clpc_pkg::LED_AG);
            end
            default:
              led_states_next = led_states & ~(clpc_pkg::LED_CA | clpc_pkg::LED_CG |
                                               clpc_pkg::LED_LI | clpc_pkg::LED_AG);
          endcase
        end
      end
      clpc_pkg::ACT_SET_JUMP: begin
        if (mode_code <= clpc_pkg::JMP_PACK_ERR && mode_code != jump_mode) begin
          jump_mode_next = mode_code;
          case (mode_code)
            clpc_pkg::JMP_ACTIVE:
              led_states_next = (led_states | clpc_pkg::LED_JG) & ~clpc_pkg::LED_JA;
            clpc_pkg::JMP_DONE:
              led_states_next = (led_states | clpc_pkg::LED_JA) & ~clpc_pkg::LED_JG;
            default:
              led_states_next = led_states & ~(clpc_pkg::LED_JA | clpc_pkg::LED_JG);
          endcase
        end
      end
      clpc_pkg::ACT_SET_ERROR: begin
        if (mode_code != clpc_pkg::ERR_NONE && mode_code <= clpc_pkg::ERR_LOW_PACK &&
            mode_code != error_mode) begin
          error_mode_next = mode_code;
          if (mode_code == clpc_pkg::ERR_POLARITY) begin
            led_states_next = clpc_pkg::LED_CA;
          end else begin
            if (mode_code == clpc_pkg::ERR_LOW_PACK)
              blink_slot_next = '0;
            charge_mode_next = clpc_pkg::CHG_OFF;
            jump_mode_next   = clpc_pkg::JMP_OFF;
            led_states_next  = '0;
          end
        end
      end
      clpc_pkg::ACT_ALL_ON: begin
        error_mode_next  = clpc_pkg::ERR_NONE;
        charge_mode_next = clpc_pkg::CHG_OFF;
        jump_mode_next   = clpc_pkg::JMP_OFF;
        led_states_next  = clpc_pkg::LED_ALL;
      end
      clpc_pkg::ACT_ALL_OFF: begin
        error_mode_next  = clpc_pkg::ERR_NONE;
        charge_mode_next = clpc_pkg::CHG_OFF;
        jump_mode_next   = clpc_pkg::JMP_OFF;
        led_states_next  = '0;
      end
      clpc_pkg::ACT_CHARGE_OFF: begin
        charge_mode_next = clpc_pkg::CHG_OFF;
        led_states_next  = led_states & ~(clpc_pkg::LED_CA | clpc_pkg::LED_CG |
                                          clpc_pkg::LED_LI | clpc_pkg::LED_AG);
      end
      clpc_pkg::ACT_JUMP_OFF: begin
        jump_mode_next  = clpc_pkg::JMP_OFF;
        led_states_next = led_states & ~(clpc_pkg::LED_JA | clpc_pkg::LED_JG);
      end
      clpc_pkg::ACT_CHEMISTRY: begin
        led_states_next = (led_states & ~(clpc_pkg::LED_LI | clpc_pkg::LED_AG))
                        | (lithium_on ? clpc_pkg::LED_LI : '0)
                        | (agm_on ? clpc_pkg::LED_AG : '0);
      end
      clpc_pkg::ACT_PACK_LEVEL: shown_level_next = graded;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      error_mode  <= clpc_pkg::ERR_NONE;
      charge_mode <= clpc_pkg::CHG_OFF;
      jump_mode   <= clpc_pkg::JMP_OFF;
      blink_slot  <= '0;
      led_states  <= '0;
      shown_level <= '0;
    end else if (accept_in) begin
      error_mode  <= error_mode_next;
      charge_mode <= charge_mode_next;
      jump_mode   <= jump_mode_next;
      blink_slot  <= blink_slot_next;
      led_states  <= led_states_next;
      shown_level <= shown_level_next;
    end
  end

  assign res_new.leds  = led_states_next;
  assign res_new.level = shown_level_next;

  // output register plus one skid beat
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take_out) begin
      if (skid_valid) begin
        res_out    <= res_skid;
        skid_valid <= 1'b0;
      end else if (accept_in) begin
        res_out <= res_new;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (accept_in) begin
      if (out_valid) begin
        res_skid   <= res_new;
        skid_valid <= 1'b1;
      end else begin
        res_out   <= res_new;
        out_valid <= 1'b1;
      end
    end
  end

  assign charge_amber = res_out.leds[0];
  assign charge_green = res_out.leds[1];
  assign jump_amber   = res_out.leds[2];
  assign jump_green   = res_out.leds[3];
  assign lithium_led  = res_out.leds[4];
  assign agm_led      = res_out.leds[5];
  assign pack_level   = res_out.level;

endmodule
`default_nettype wire

// ----- rtl/clpc_checker.sv -----
// Port-level assertions for the charger LED pattern controller, bound to the top level.
`default_nettype none
module clpc_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           in_valid,
  input wire logic                           in_stall,
  input wire logic                           out_valid,
  input wire logic                           out_stall,
  input wire logic                           charge_amber,
  input wire logic                           charge_green,
  input wire logic                           jump_amber,
  input wire logic                           jump_green,
  input wire logic                           lithium_led,
  input wire logic                           agm_led,
  input wire logic [clpc_pkg::LEVEL_W-1:0]   pack_level
);

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pack_level <= 3'd5)
    else $error("pack_level above five");

  a_out_from_accept: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall))
    else $error("result beat without an accepted input beat");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("input stalled while output was free");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid &&
      $stable({charge_amber, charge_green, jump_amber, jump_green,
               lithium_led, agm_led, pack_level}))
    else $error("stalled result beat changed");

endmodule

bind charger_led_pattern_controller clpc_checker u_clpc_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .charge_amber (charge_amber),
  .charge_green (charge_green),
  .jump_amber   (jump_amber),
  .jump_green   (jump_green),
  .lithium_led  (lithium_led),
  .agm_led      (agm_led),
  .pack_level   (pack_level)
);
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the charger LED pattern controller: directed, threshold and random events.
module tb_top;
  import clpc_pkg::*;

  localparam int PATTERN_SLOTS = 10;
  localparam int IDLE_LIMIT    = 2000;
  localparam int IDLE_TAIL     = 4;
  localparam int MAX_PRINTS    = 50;

  localparam logic [ACTION_W-1:0]  ACT_UNUSED   = 4'd15;
  localparam logic [MODE_W-1:0]    JMP_UNUSED_LO = 3'd5;
  localparam logic [MODE_W-1:0]    JMP_UNUSED_HI = 3'd7;
  localparam logic [MODE_W-1:0]    ERR_UNUSED   = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED   = 3'd7;

  logic clk;
  logic rst = 1'b1;

  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [ACTION_W-1:0]        action = '0;
  logic [MODE_W-1:0]          mode_code = '0;
  logic                       lithium_on = 1'b0;
  logic                       agm_on = 1'b0;
  logic signed [PACK_W-1:0]   pack_millivolts = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic                       charge_amber;
  logic                       charge_green;
  logic                       jump_amber;
  logic                       jump_green;
  logic                       lithium_led;
  logic                       agm_led;
  logic [LEVEL_W-1:0]         pack_level;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [MV_W-1:0]            cfg_data = '0;

  charger_led_pattern_controller #(.PATTERN_SLOTS(PATTERN_SLOTS)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .mode_code(mode_code), .lithium_on(lithium_on), .agm_on(agm_on),
    .pack_millivolts(pack_millivolts),
    .out_valid(out_valid), .out_stall(out_stall),
    .charge_amber(charge_amber), .charge_green(charge_green),
    .jump_amber(jump_amber), .jump_green(jump_green),
    .lithium_led(lithium_led), .agm_led(agm_led), .pack_level(pack_level),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Predicted controller state
  logic [MODE_W-1:0]  err_md = ERR_NONE;
  logic [MODE_W-1:0]  chg_md = CHG_OFF;
  logic [MODE_W-1:0]  jmp_md = JMP_OFF;
  logic [3:0]         blink = '0;
  logic [LED_W-1:0]   leds = '0;
  logic [LEVEL_W-1:0] level = '0;
  logic [MV_W-1:0]    thr_mv [5] = '{RST_MAINTAIN, RST_HIGH, RST_JUMP_READY, RST_ACCESSORY,
                                     RST_LOW};

  result_t led_beats_due [$];
  result_t want_beat;

  int fail_count = 0;
  int items_sent = 0;
  int results_checked = 0;
  int cfg_writes = 0;
  int pack_events = 0;
  int no_gap_left = 0;
  int stall_left = 0;
  int stall_pick;
  int idle_cycles = 0;

  function automatic void set_leds(logic [LED_W-1:0] mask, logic on);
    if (on) leds = leds | mask;
    else leds = leds & ~mask;
  endfunction

  function automatic void step_pattern(logic [LED_W-1:0] mask, int pulses);
    set_leds(mask, (blink[0] == 1'b0) && (int'(blink) < 2 * pulses));
    if (int'(blink) < PATTERN_SLOTS - 1) blink = blink + 4'd1;
    else blink = '0;
  endfunction

  function automatic void clear_modes(logic on);
    err_md = ERR_NONE;
    chg_md = CHG_OFF;
    jmp_md = JMP_OFF;
    set_leds(LED_ALL, on);
  endfunction

  function automatic void charge_pair_off();
    chg_md = CHG_OFF;
    set_leds(LED_CA | LED_CG | LED_LI | LED_AG, 1'b0);
  endfunction

  function automatic void jump_pair_off();
    jmp_md = JMP_OFF;
    set_leds(LED_JA | LED_JG, 1'b0);
  endfunction

  function automatic result_t led_state_after(logic [ACTION_W-1:0] act, logic [MODE_W-1:0] code,
                                              logic li, logic ag, logic signed [PACK_W-1:0] mv);
    result_t r;
    int v;
    v = mv;
    case (act)
      ACT_TICK: begin
        if (err_md == ERR_NONE) begin
          case (chg_md)
            CHG_WAIT:     leds = leds ^ LED_CA;
            CHG_CV:       leds = leds ^ LED_CG;
            CHG_SULFATED: step_pattern(LED_CA | LED_CG, 1);
            CHG_RECOV_TO: step_pattern(LED_CA | LED_CG, 2);
            CHG_CC_TO:    step_pattern(LED_CA | LED_CG, 3);
            default: ;
          endcase
          case (jmp_md)
            JMP_WAIT:     leds = leds ^ LED_JG;
            JMP_PACK_ERR: leds = leds ^ LED_JA;
            default: ;
          endcase
        end else begin
          case (err_md)
            ERR_UNCAL:      step_pattern(LED_CA | LED_CG, 1);
            ERR_CAL_OK:     leds = leds ^ (LED_CG | LED_JG);
            ERR_TEST:       leds = leds ^ LED_ALL;
            ERR_POLARITY:   leds = leds ^ (LED_CA | LED_CG);
            ERR_CONTENTION: leds = leds ^ (LED_CA | LED_JA);
            ERR_LOW_PACK:   step_pattern(LED_JA, 1);
            default: ;
          endcase
        end
      end
      ACT_SET_CHARGE: begin
        if (code != chg_md) begin
          case (code)
            CHG_OFF:  charge_pair_off();
            CHG_WAIT: set_leds(LED_CA | LED_CG, 1'b0);
            CHG_CHARGING, CHG_CV: begin
              set_leds(LED_CA, 1'b1);
              set_leds(LED_CG, 1'b0);
            end
            CHG_MAINT: begin
              set_leds(LED_CG, 1'b1);
              set_leds(LED_CA, 1'b0);
            end
            default: begin
              blink = '0;
              charge_pair_off();
            end
          endcase
          chg_md = code;
        end
      end
      ACT_SET_JUMP: begin
        if (code <= JMP_PACK_ERR && code != jmp_md) begin
          case (code)
            JMP_ACTIVE: begin
              set_leds(LED_JG, 1'b1);
              set_leds(LED_JA, 1'b0);
            end
            JMP_DONE: begin
              set_leds(LED_JA, 1'b1);
              set_leds(LED_JG, 1'b0);
            end
            default: jump_pair_off();
          endcase
          jmp_md = code;
        end
      end
      ACT_SET_ERROR: begin
        if (code != ERR_NONE && code <= ERR_LOW_PACK && code != err_md) begin
          if (code == ERR_POLARITY) begin
            leds = LED_CA;
          end else begin
            if (code == ERR_LOW_PACK) blink = '0;
            clear_modes(1'b0);
          end
          err_md = code;
        end
      end
      ACT_ALL_ON:     clear_modes(1'b1);
      ACT_ALL_OFF:    clear_modes(1'b0);
      ACT_CHARGE_OFF: charge_pair_off();
      ACT_JUMP_OFF:   jump_pair_off();
      ACT_CHEMISTRY: begin
        set_leds(LED_LI, li);
        set_leds(LED_AG, ag);
      end
      ACT_PACK_LEVEL: begin
        if (v > int'(thr_mv[CFG_MAINTAIN])) level = 3'd5;
        else if (v > int'(thr_mv[CFG_HIGH])) level = 3'd4;
        else if (v > int'(thr_mv[CFG_JUMP_READY])) level = 3'd3;
        else if (v > int'(thr_mv[CFG_ACCESSORY])) level = 3'd2;
        else if (v > int'(thr_mv[CFG_LOW])) level = 3'd1;
        else level = 3'd0;
      end
      default: ;
    endcase
    r.leds = leds;
    r.level = level;
    return r;
  endfunction

  task automatic report_fail(input string msg);
    if (fail_count < MAX_PRINTS) $display("MISMATCH: %s", msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      report_fail($sformatf("beat %0d %s got %0d expected %0d", results_checked, name, got, want));
  endtask

  // Output side stalls: mostly short runs, a few long ones, and long stall-free stretches
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 50) begin
        out_stall <= 1'b0;
        stall_left <= $urandom_range(0, 7);
      end else if (stall_pick < 85) begin
        out_stall <= 1'b1;
        stall_left <= $urandom_range(0, 2);
      end else if (stall_pick < 95) begin
        out_stall <= 1'b0;
        stall_left <= $urandom_range(40, 150);
      end else begin
        out_stall <= 1'b1;
        stall_left <= $urandom_range(10, 40);
      end
    end
  end

  // Sampled mid-cycle: a beat seen here is taken at the next rising edge
  always @(negedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (led_beats_due.size() == 0) begin
        report_fail("result beat with no event pending");
      end else begin
        want_beat = led_beats_due.pop_front();
        check_field("charge_amber", int'(charge_amber), int'((want_beat.leds & LED_CA) != '0));
        check_field("charge_green", int'(charge_green), int'((want_beat.leds & LED_CG) != '0));
        check_field("jump_amber", int'(jump_amber), int'((want_beat.leds & LED_JA) != '0));
        check_field("jump_green", int'(jump_green), int'((want_beat.leds & LED_JG) != '0));
        check_field("lithium_led", int'(lithium_led), int'((want_beat.leds & LED_LI) != '0));
        check_field("agm_led", int'(agm_led), int'((want_beat.leds & LED_AG) != '0));
        check_field("pack_level", int'(pack_level), int'(want_beat.level));
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no beat moved for %0d cycles", IDLE_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_event(input logic [ACTION_W-1:0] act, input logic [MODE_W-1:0] code,
                            input logic li, input logic ag, input logic signed [PACK_W-1:0] mv);
    int gap;
    int pick;
    in_valid <= 1'b1;
    action <= act;
    mode_code <= code;
    lithium_on <= li;
    agm_on <= ag;
    pack_millivolts <= mv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    led_beats_due.push_back(led_state_after(act, code, li, ag, mv));
    items_sent++;
    if (act == ACT_PACK_LEVEL) pack_events++;
    gap = 0;
    if (no_gap_left > 0) begin
      no_gap_left--;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 3) no_gap_left = $urandom_range(20, 80);
      else if (pick < 60) gap = 0;
      else if (pick < 88) gap = $urandom_range(1, 3);
      else if (pick < 97) gap = $urandom_range(4, 10);
      else gap = $urandom_range(15, 50);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [MODE_W-1:0] rand_code(int lo, int hi);
    return MODE_W'($urandom_range(hi, lo));
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic logic signed [PACK_W-1:0] pick_pack_mv();
    int v;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      v = int'(thr_mv[$urandom_range(0, 4)]) + int'($urandom_range(0, 4)) - 2;
    end else if (pick < 85) begin
      v = int'($urandom_range(0, 65535));
    end else begin
      case ($urandom_range(0, 3))
        0: v = -32768;
        1: v = 32767;
        2: v = 0;
        default: v = -1;
      endcase
    end
    return PACK_W'(v);
  endfunction

  task automatic send_ticks(input int n);
    repeat (n) send_event(ACT_TICK, rand_code(0, 7), rand_bit(), rand_bit(), pick_pack_mv());
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (led_beats_due.size() != 0) @(posedge clk);
    repeat (IDLE_TAIL) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [CFG_IDX_W-1:0] idx, input logic [MV_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx <= CFG_LOW) thr_mv[idx] = val;
    cfg_writes++;
  endtask

  task automatic load_thresholds(input logic [MV_W-1:0] m, input logic [MV_W-1:0] h,
                                 input logic [MV_W-1:0] j, input logic [MV_W-1:0] a,
                                 input logic [MV_W-1:0] l);
    wait_idle();
    write_threshold(CFG_MAINTAIN, m);
    write_threshold(CFG_HIGH, h);
    write_threshold(CFG_JUMP_READY, j);
    write_threshold(CFG_ACCESSORY, a);
    write_threshold(CFG_LOW, l);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_directed_events();
    send_event(ACT_TICK, CHG_OFF, 1'b0, 1'b0, '0);
    send_event(ACT_SET_CHARGE, CHG_OFF, 1'b0, 1'b0, '0);
    send_event(ACT_CHEMISTRY, CHG_OFF, 1'b1, 1'b1, '0);
    send_event(ACT_SET_CHARGE, CHG_SULFATED, 1'b0, 1'b0, '0);
    send_ticks(2);
    // uncalibrated blink picks up from the current slot
    send_event(ACT_SET_ERROR, ERR_UNCAL, 1'b0, 1'b0, '0);
    send_event(ACT_TICK, CHG_OFF, 1'b0, 1'b0, '0);
    send_event(ACT_SET_ERROR, ERR_UNCAL, 1'b0, 1'b0, '0);
    send_event(ACT_SET_ERROR, ERR_NONE, 1'b0, 1'b0, '0);
    send_event(ACT_SET_ERROR, ERR_UNUSED, 1'b0, 1'b0, '0);
    send_event(ACT_ALL_OFF, CHG_OFF, 1'b0, 1'b0, '0);
    send_event(ACT_SET_CHARGE, CHG_CV, 1'b0, 1'b0, '0);
    send_event(ACT_SET_JUMP, JMP_WAIT, 1'b0, 1'b0, '0);
    // polarity keeps charge and jump modes
    send_event(ACT_SET_ERROR, ERR_POLARITY, 1'b0, 1'b0, '0);
    send_event(ACT_TICK, CHG_OFF, 1'b0, 1'b0, '0);
    send_event(ACT_ALL_ON, CHG_OFF, 1'b0, 1'b0, '0);
    send_event(ACT_SET_JUMP, JMP_UNUSED_LO, 1'b0, 1'b0, '0);
    send_event(ACT_SET_JUMP, JMP_UNUSED_HI, 1'b0, 1'b0, '0);
    send_event(ACT_SET_JUMP, JMP_OFF, 1'b0, 1'b0, '0);
    send_event(ACT_SET_JUMP, JMP_ACTIVE, 1'b0, 1'b0, '0);
    send_event(ACT_SET_JUMP, JMP_OFF, 1'b0, 1'b0, '0);
    send_event(ACT_CHEMISTRY, CHG_OFF, 1'b1, 1'b0, '0);
    send_event(ACT_CHARGE_OFF, CHG_OFF, 1'b0, 1'b0, '0);
    send_event(ACT_JUMP_OFF, CHG_OFF, 1'b0, 1'b0, '0);
    send_event(ACT_UNUSED, CHG_OFF, 1'b1, 1'b1, '0);
  endtask

  task automatic probe_thresholds();
    int v;
    for (int i = 0; i < 5; i++) begin
      for (int d = -1; d <= 1; d++) begin
        v = int'(thr_mv[i]) + d;
        send_event(ACT_PACK_LEVEL, rand_code(0, 7), rand_bit(), rand_bit(), PACK_W'(v));
      end
    end
    send_event(ACT_PACK_LEVEL, CHG_OFF, 1'b0, 1'b0, 16'sh8000);
    send_event(ACT_PACK_LEVEL, CHG_OFF, 1'b0, 1'b0, 16'sh7FFF);
    send_event(ACT_PACK_LEVEL, CHG_OFF, 1'b0, 1'b0, 16'sh0000);
    send_event(ACT_PACK_LEVEL, CHG_OFF, 1'b0, 1'b0, 16'shFFFF);
  endtask

  task automatic test_pack_thresholds();
    probe_thresholds();
    load_thresholds('0, '0, '0, '0, '0);
    probe_thresholds();
    load_thresholds('1, '1, '1, '1, '1);
    probe_thresholds();
    // out-of-range index must leave every threshold alone
    wait_idle();
    write_threshold(CFG_UNUSED, '1);
    cfg_valid <= 1'b0;
    load_thresholds(15'd1000, 15'd2000, 15'd3000, 15'd4000, 15'd5000);
    probe_thresholds();
    load_thresholds(MV_W'($urandom_range(0, 32767)), MV_W'($urandom_range(0, 32767)),
                    MV_W'($urandom_range(0, 32767)), MV_W'($urandom_range(0, 32767)),
                    MV_W'($urandom_range(0, 32767)));
    probe_thresholds();
  endtask

  task automatic run_scenario();
    case ($urandom_range(0, 3))
      0: begin
        send_event(ACT_SET_CHARGE, rand_code(0, 7), rand_bit(), rand_bit(), pick_pack_mv());
        if (rand_bit())
          send_event(ACT_CHEMISTRY, rand_code(0, 7), rand_bit(), rand_bit(), pick_pack_mv());
        send_ticks($urandom_range(1, 25));
      end
      1: begin
        send_event(ACT_SET_JUMP, ($urandom_range(0, 9) == 0) ? rand_code(5, 7) : rand_code(0, 4),
                   rand_bit(), rand_bit(), pick_pack_mv());
        send_ticks($urandom_range(1, 25));
      end
      2: begin
        send_event(ACT_SET_CHARGE, rand_code(0, 7), rand_bit(), rand_bit(), pick_pack_mv());
        send_event(ACT_SET_JUMP, rand_code(0, 4), rand_bit(), rand_bit(), pick_pack_mv());
        send_ticks($urandom_range(1, 20));
        case ($urandom_range(0, 3))
          0: send_event(ACT_CHARGE_OFF, rand_code(0, 7), rand_bit(), rand_bit(), pick_pack_mv());
          1: send_event(ACT_JUMP_OFF, rand_code(0, 7), rand_bit(), rand_bit(), pick_pack_mv());
          2: send_event(ACT_SET_CHARGE, CHG_OFF, rand_bit(), rand_bit(), pick_pack_mv());
          default: send_event(ACT_SET_JUMP, JMP_OFF, rand_bit(), rand_bit(), pick_pack_mv());
        endcase
        send_ticks($urandom_range(1, 12));
      end
      default: begin
        send_event(ACT_SET_ERROR, rand_code(1, 6), rand_bit(), rand_bit(), pick_pack_mv());
        send_ticks($urandom_range(1, 25));
        if ($urandom_range(0, 9) < 6)
          send_event(ACT_ALL_OFF, rand_code(0, 7), rand_bit(), rand_bit(), pick_pack_mv());
        else if ($urandom_range(0, 1) == 0)
          send_event(ACT_ALL_ON, rand_code(0, 7), rand_bit(), rand_bit(), pick_pack_mv());
        else
          send_event(ACT_SET_ERROR, rand_code(0, 7), rand_bit(), rand_bit(), pick_pack_mv());
      end
    endcase
    if ($urandom_range(0, 9) < 3)
      send_event(ACT_PACK_LEVEL, rand_code(0, 7), rand_bit(), rand_bit(), pick_pack_mv());
  endtask

  task automatic test_random_sequences();
    int target;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase % 3)
        0: load_thresholds(RST_MAINTAIN, RST_HIGH, RST_JUMP_READY, RST_ACCESSORY, RST_LOW);
        1: load_thresholds(MV_W'($urandom_range(0, 32767)), MV_W'($urandom_range(0, 32767)),
                           MV_W'($urandom_range(0, 32767)), MV_W'($urandom_range(0, 32767)),
                           MV_W'($urandom_range(0, 32767)));
        default: load_thresholds(MV_W'($urandom_range(20000, 32767)),
                                 MV_W'($urandom_range(10000, 20000)),
                                 MV_W'($urandom_range(5000, 10000)),
                                 MV_W'($urandom_range(100, 5000)),
                                 MV_W'($urandom_range(0, 100)));
      endcase
      target = items_sent + 285;
      while (items_sent < target) begin
        if ($urandom_range(0, 99) < 70)
          run_scenario();
        else
          send_event(ACTION_W'($urandom_range(0, 15)), rand_code(0, 7), rand_bit(), rand_bit(),
                     PACK_W'($urandom_range(0, 65535)));
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_events();
    test_pack_thresholds();
    test_random_sequences();
    wait_idle();
    if (led_beats_due.size() != 0)
      report_fail($sformatf("%0d result beats never arrived", led_beats_due.size()));
    $display("Sent %0d events (directed, threshold probes, random mode sequences), checked %0d beats",
             items_sent, results_checked);
    $display("Wrote %0d thresholds, graded %0d pack voltages, %0d mismatches",
             cfg_writes, pack_events, fail_count);
    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
